FILE: sv/gaussian_rbf_network_eval_macros.svh
// assertion helpers shared by the rbf evaluator
`ifndef GAUSSIAN_RBF_NETWORK_EVAL_MACROS_SVH
`define GAUSSIAN_RBF_NETWORK_EVAL_MACROS_SVH

// same-cycle implication, held off during reset
`define RBF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbf same-cycle check failed");

// next-cycle implication, held off during reset
`define RBF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbf next-cycle check failed");

`endif

FILE: sv/rbf_pkg.sv
`default_nettype none
package rbf_pkg;

  localparam int MAX_BASES = 64;
  localparam int MAX_DIMS  = 8;
  localparam int FRAC_BITS = 16;
  localparam int BASE_W    = 6;
  localparam int DIM_W     = 3;
  localparam int ADDR_W    = BASE_W + DIM_W;

  localparam int EXP_ENTRIES = 257;
  // exp(-1/16) in q30 from an eight term series
  localparam logic [63:0] EXP_STEP = 64'd1008687096;

  localparam logic [1:0] OP_CENTER = 2'd0;
  localparam logic [1:0] OP_WIDTH  = 2'd1;
  localparam logic [1:0] OP_WEIGHT = 2'd2;
  localparam logic [1:0] OP_COORD  = 2'd3;

  localparam logic [1:0] CFG_NUM_BASES = 2'd0;
  localparam logic [1:0] CFG_NUM_DIMS  = 2'd1;
  localparam logic [1:0] CFG_GRAD_EN   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_E_RD,
    ST_E_DIF,
    ST_E_SQ,
    ST_E_P,
    ST_E_ACC,
    ST_PHI0,
    ST_PHI1,
    ST_U,
    ST_UACC,
    ST_G_RD,
    ST_G_DIF,
    ST_G_MUL,
    ST_G_P,
    ST_G_ACC,
    ST_EMIT
  } rbf_state_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         axis;
    logic signed [63:0] acc;
    logic               last;
  } rbf_res_t;

  typedef logic [30:0] exp_tab_t [EXP_ENTRIES];

  function automatic exp_tab_t build_exp();
    exp_tab_t    t;
    logic [63:0] v;
    v = 64'd1 << 30;
    t[0] = v[30:0];
    for (int k = 1; k < EXP_ENTRIES; k++) begin
      v = (v * EXP_STEP + (64'd1 << 29)) >> 30;
      t[k] = v[30:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp();

endpackage
`default_nettype wire

FILE: sv/rbf_ram.sv
`default_nettype none
module rbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: sv/rbf_phi.sv
`default_nettype none
module rbf_phi (
  input  wire logic               clk,
  input  wire logic signed [44:0] expo,
  output logic             [30:0] phi
);
  import rbf_pkg::*;

  localparam logic signed [44:0] EXP_LIMIT = 45'sd1048576;

  logic        one_r, zero_r;
  logic [30:0] tk_r, diff_r, phi_r;
  logic [11:0] fr_r;
  logic [8:0]  k0, k1;
  logic [42:0] slope;

  assign k0 = {1'b0, expo[19:12]};
  assign k1 = k0 + 9'd1;

  // table lookup, then linear interpolation between neighbouring entries
  always_ff @(posedge clk) begin
    one_r  <= (expo <= 45'sd0);
    zero_r <= (expo >= EXP_LIMIT);
    tk_r   <= EXP_TAB[k0];
    diff_r <= EXP_TAB[k0] - EXP_TAB[k1];
    fr_r   <= expo[11:0];
  end

  assign slope = 43'(diff_r) * 43'(fr_r);

  always_ff @(posedge clk) begin
    if (one_r) begin
      phi_r <= 31'd1 << 30;
    end else if (zero_r) begin
      phi_r <= 31'd0;
    end else begin
      phi_r <= tk_r - slope[42:12];
    end
  end

  assign phi = phi_r;

endmodule
`default_nettype wire

FILE: sv/rbf_out.sv
`default_nettype none
module rbf_out (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire rbf_pkg::rbf_res_t res,
  output logic                   free,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,  // axis, result_value
  output logic [1:0]             out_tuser,  // kind, saturated
  output logic                   out_tlast
);
  import rbf_pkg::*;

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  logic        valid_r;
  logic        kind_r, sat_r, last_r;
  logic [2:0]  axis_r;
  logic [31:0] val_r;

  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res.kind;
      axis_r <= res.axis;
      last_r <= res.last;
      if (res.acc > SAT_HI) begin
        val_r <= SAT_HI[31:0];
        sat_r <= 1'b1;
      end else if (res.acc < SAT_LO) begin
        val_r <= SAT_LO[31:0];
        sat_r <= 1'b1;
      end else begin
        val_r <= res.acc[31:0];
        sat_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, val_r, axis_r};
  assign out_tuser  = {sat_r, kind_r};
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

FILE: sv/gaussian_rbf_network_eval.sv
// gaussian rbf network evaluator, signed q16.16
// input channel: each word is a load (center, width, weight) or a query
// coordinate, chosen by in_tuser. loads and coordinates are taken only while
// idle. the coordinate for axis num_dims-1 starts a query; in_tready stays
// low until every result of that query has entered the output register.
// a query walks the bases one at a time, reading centre and width memories
// once per axis for the exponent, then evaluates exp and the weight product,
// and with gradients on reads the memories again, once per axis, for the
// gradient terms. after the last basis it emits the results one at a time.
// output channel: one value word, then one gradient word per axis when
// enabled, tlast on the final word. a single output register holds a word
// while the receiver stalls; the sequencer waits for it to drain.
// reset clears control and configuration (one basis, one axis,
// gradients on); memories are not cleared and must be loaded before use.
`default_nettype none
`include "gaussian_rbf_network_eval_macros.svh"
module gaussian_rbf_network_eval (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // basis_index, dim_index, value
  input  wire logic [1:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // axis, result_value
  output logic [1:0]       out_tuser,  // kind, saturated
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [6:0]  cfg_wdata
);
  import rbf_pkg::*;

  localparam logic [40:0]  ARG_CAP  = 41'd1 << 40;
  localparam logic [80:0]  GRAD_LIM = 81'd1 << 62;
  localparam logic [54:0]  GRAD_CAP = 55'd1 << 54;

  rbf_state_t state_r, state_nxt;

  logic [6:0] nbases_r;
  logic [3:0] ndims_r;
  logic       grad_en_r;

  logic [BASE_W-1:0] j_r;
  logic [DIM_W-1:0]  i_r;
  logic [3:0]        e_r;

  logic [31:0]        q_r [MAX_DIMS];
  logic signed [32:0] dif_r;
  logic [31:0]        ad_r;
  logic signed [31:0] r_r;
  logic [47:0]        sq_r;
  logic [55:0]        p0_r, p1_r;
  logic signed [44:0] ea_r;
  logic signed [32:0] u_r;
  logic signed [37:0] va_r;
  logic [48:0]        aw_r;
  logic               wneg_r;
  logic [56:0]        g0_r;
  logic [55:0]        g1_r;
  logic signed [63:0] ga_r [MAX_DIMS];

  logic [1:0]  in_op;
  logic [5:0]  in_basis;
  logic [2:0]  in_dim;
  logic [31:0] in_value;
  logic        in_acc, start_q;

  logic [BASE_W-1:0] nb_m1;
  logic [DIM_W-1:0]  nd_m1;
  logic [6:0]        nbm;
  logic [3:0]        ndm;
  logic              i_last, j_last;

  logic [31:0] c_rd, w_rd, wt_rd;
  logic [30:0] phi;

  logic signed [32:0] dif_w;
  logic [32:0]        ad_w;
  logic [63:0]        sq_prod;
  logic [31:0]        ar;
  logic [79:0]        e_tot;
  logic [63:0]        e_ts;
  logic [40:0]        e_t;
  logic signed [63:0] wprod;
  logic signed [64:0] gprod;
  logic signed [48:0] w_w;
  logic [48:0]        aw_w;
  logic [32:0]        au_w;
  logic [80:0]        g_tot;
  logic [54:0]        g_m;
  logic               g_neg;

  logic     emit_load, emit_last, out_free;
  rbf_res_t res;

  assign in_op    = in_tuser;
  assign in_basis = in_tdata[5:0];
  assign in_dim   = in_tdata[8:6];
  assign in_value = in_tdata[40:9];
  assign in_acc   = in_tvalid && in_tready;
  assign start_q  = (in_op == OP_COORD) && (in_dim == nd_m1);

  assign nbm   = nbases_r - 7'd1;
  assign ndm   = ndims_r - 4'd1;
  assign nb_m1 = (nbases_r == 7'd0) ? '0 :
                 (nbases_r > 7'(MAX_BASES)) ? BASE_W'(MAX_BASES - 1) : nbm[BASE_W-1:0];
  assign nd_m1 = (ndims_r == 4'd0) ? '0 :
                 (ndims_r > 4'(MAX_DIMS)) ? DIM_W'(MAX_DIMS - 1) : ndm[DIM_W-1:0];
  assign i_last = (i_r == nd_m1);
  assign j_last = (j_r == nb_m1);

  rbf_ram #(.WIDTH(32), .DEPTH(MAX_BASES * MAX_DIMS)) u_center (
    .clk   (clk),
    .we    (in_acc && in_op == OP_CENTER),
    .waddr ({in_basis, in_dim}),
    .wdata (in_value),
    .raddr ({j_r, i_r}),
    .rdata (c_rd)
  );

  rbf_ram #(.WIDTH(32), .DEPTH(MAX_BASES * MAX_DIMS)) u_width (
    .clk   (clk),
    .we    (in_acc && in_op == OP_WIDTH),
    .waddr ({in_basis, in_dim}),
    .wdata (in_value),
    .raddr ({j_r, i_r}),
    .rdata (w_rd)
  );

  rbf_ram #(.WIDTH(32), .DEPTH(MAX_BASES)) u_weight (
    .clk   (clk),
    .we    (in_acc && in_op == OP_WEIGHT),
    .waddr (in_basis),
    .wdata (in_value),
    .raddr (j_r),
    .rdata (wt_rd)
  );

  rbf_phi u_phi (
    .clk  (clk),
    .expo (ea_r),
    .phi  (phi)
  );

  rbf_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit_load),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && start_q) state_nxt = ST_E_RD;
      ST_E_RD:  state_nxt = ST_E_DIF;
      ST_E_DIF: state_nxt = ST_E_SQ;
      ST_E_SQ:  state_nxt = ST_E_P;
      ST_E_P:   state_nxt = ST_E_ACC;
      ST_E_ACC: state_nxt = i_last ? ST_PHI0 : ST_E_RD;
      ST_PHI0:  state_nxt = ST_PHI1;
      ST_PHI1:  state_nxt = ST_U;
      ST_U:     state_nxt = ST_UACC;
      ST_UACC: begin
        if (grad_en_r) state_nxt = ST_G_RD;
        else           state_nxt = j_last ? ST_EMIT : ST_E_RD;
      end
      ST_G_RD:  state_nxt = ST_G_DIF;
      ST_G_DIF: state_nxt = ST_G_MUL;
      ST_G_MUL: state_nxt = ST_G_P;
      ST_G_P:   state_nxt = ST_G_ACC;
      ST_G_ACC: begin
        if (!i_last)     state_nxt = ST_G_RD;
        else if (j_last) state_nxt = ST_EMIT;
        else             state_nxt = ST_E_RD;
      end
      ST_EMIT:  if (out_free && emit_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    emit_load = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EMIT: emit_load = out_free;
      default: ;
    endcase
  end

  assign emit_last = (e_r == 4'd0) ? !grad_en_r : (e_r == {1'b0, nd_m1} + 4'd1);
  assign res.kind  = (e_r != 4'd0);
  assign res.axis  = (e_r == 4'd0) ? 3'd0 : 3'(e_r - 4'd1);
  assign res.acc   = (e_r == 4'd0) ? 64'(va_r) : ga_r[3'(e_r - 4'd1)];
  assign res.last  = emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      nbases_r  <= 7'd1;
      ndims_r   <= 4'd1;
      grad_en_r <= 1'b1;
      j_r       <= '0;
      i_r       <= '0;
      e_r       <= '0;
      ea_r      <= '0;
      va_r      <= '0;
      for (int k = 0; k < MAX_DIMS; k++) ga_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_NUM_BASES: nbases_r  <= cfg_wdata;
          CFG_NUM_DIMS:  ndims_r   <= cfg_wdata[3:0];
          CFG_GRAD_EN:   grad_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && start_q) begin
            j_r  <= '0;
            i_r  <= '0;
            e_r  <= '0;
            ea_r <= '0;
            va_r <= '0;
            for (int k = 0; k < MAX_DIMS; k++) ga_r[k] <= '0;
          end
        end
        ST_E_ACC: begin
          ea_r <= r_r[31] ? ea_r - $signed({4'd0, e_t}) : ea_r + $signed({4'd0, e_t});
          i_r  <= i_last ? '0 : i_r + 1'b1;
        end
        ST_U: ea_r <= '0;
        ST_UACC: begin
          va_r <= va_r + {{5{u_r[32]}}, u_r};
          if (!grad_en_r && !j_last) j_r <= j_r + 1'b1;
        end
        ST_G_ACC: begin
          ga_r[i_r] <= g_neg ? ga_r[i_r] - $signed({9'd0, g_m})
                             : ga_r[i_r] + $signed({9'd0, g_m});
          i_r <= i_last ? '0 : i_r + 1'b1;
          if (i_last && !j_last) j_r <= j_r + 1'b1;
        end
        ST_EMIT: if (out_free) e_r <= e_r + 4'd1;
        default: ;
      endcase
    end
  end

  // datapath arithmetic
  assign dif_w   = $signed({q_r[i_r][31], q_r[i_r]}) - $signed({c_rd[31], c_rd});
  assign ad_w    = dif_w[32] ? (33'd0 - dif_w) : dif_w;
  assign sq_prod = 64'(ad_r) * 64'(ad_r);
  assign ar      = r_r[31] ? (32'd0 - r_r) : r_r;
  assign e_tot   = {24'd0, p0_r} + {p1_r, 24'd0};
  assign e_ts    = e_tot[79:16];
  assign e_t     = (e_ts > 64'(ARG_CAP)) ? ARG_CAP : e_ts[40:0];
  assign wprod   = $signed(wt_rd) * $signed({1'b0, phi});
  assign gprod   = r_r * dif_r;
  assign w_w     = gprod[64:16];
  assign aw_w    = w_w[48] ? (49'd0 - w_w) : w_w;
  assign au_w    = u_r[32] ? (33'd0 - u_r) : u_r;
  assign g_tot   = {24'd0, g0_r} + {g1_r, 25'd0};
  assign g_m     = (g_tot > GRAD_LIM) ? GRAD_CAP : g_tot[69:15];
  assign g_neg   = (u_r[32] == wneg_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && in_op == OP_COORD) begin
      q_r[in_dim] <= in_value;
    end
    case (state_r)
      ST_E_DIF: begin
        ad_r <= ad_w[31:0];
        r_r  <= w_rd;
      end
      ST_E_SQ: sq_r <= sq_prod[63:16];
      ST_E_P: begin
        p0_r <= 56'(ar) * 56'(sq_r[23:0]);
        p1_r <= 56'(ar) * 56'(sq_r[47:24]);
      end
      ST_U: u_r <= wprod[62:30];
      ST_G_DIF: begin
        dif_r <= dif_w;
        r_r   <= w_rd;
      end
      ST_G_MUL: begin
        aw_r   <= aw_w;
        wneg_r <= w_w[48];
      end
      ST_G_P: begin
        g0_r <= 57'(au_w[31:0]) * 57'(aw_r[24:0]);
        g1_r <= 56'(au_w[31:0]) * 56'(aw_r[48:25]);
      end
      default: ;
    endcase
  end

  `RBF_ASSERT_IMP(a_load_free, emit_load, out_free)
  `RBF_ASSERT_IMP(a_axis_bound, (state_r == ST_E_ACC || state_r == ST_G_ACC), (i_r <= nd_m1))
  `RBF_ASSERT_NXT(a_query_start, (in_acc && start_q), (state_r == ST_E_RD))
  `RBF_ASSERT_IMP(a_emit_bound, (state_r == ST_EMIT), (e_r <= {1'b0, nd_m1} + 4'd1))

endmodule
`default_nettype wire

FILE: dv/gaussian_rbf_network_eval_test.sv
`timescale 1ns / 1ps
`default_nettype none
module gaussian_rbf_network_eval_test;
  import rbf_pkg::*;

  typedef bit [63:0] u64;

  class rbf_scoreboard;
    typedef struct {
      bit        kind;
      bit [2:0]  axis;
      bit [31:0] val;
      bit        sat;
      bit        last;
    } rbf_word_t;

    rbf_word_t   pending[$];
    int          errors;
    longint      centre_mem[MAX_BASES*MAX_DIMS];
    longint      width_mem[MAX_BASES*MAX_DIMS];
    longint      weight_mem[MAX_BASES];
    longint      query_pt[MAX_DIMS];
    u64          exp_lut[EXP_ENTRIES];
    int unsigned bases_reg;
    int unsigned dims_reg;
    bit          grad_reg;

    function new();
      longint term;
      longint e_step;
      term = 64'sd1 << 30;
      e_step = term;
      for (int n = 1; n <= 8; n++) begin
        term = (term >>> 4) / n;
        e_step += (n % 2) ? -term : term;
      end
      exp_lut[0] = 64'd1 << 30;
      for (int k = 1; k < EXP_ENTRIES; k++)
        exp_lut[k] = (exp_lut[k-1] * u64'(e_step) + (64'd1 << 29)) >> 30;
      bases_reg = 1;
      dims_reg = 1;
      grad_reg = 1;
      errors = 0;
      for (int i = 0; i < MAX_BASES*MAX_DIMS; i++) begin
        centre_mem[i] = 0;
        width_mem[i] = 0;
      end
      foreach (weight_mem[i]) weight_mem[i] = 0;
      foreach (query_pt[i]) query_pt[i] = 0;
    endfunction

    function void set_reg(logic [1:0] addr, int unsigned v);
      case (addr)
        CFG_NUM_BASES: bases_reg = v & 7'h7f;
        CFG_NUM_DIMS:  dims_reg = v & 4'hf;
        CFG_GRAD_EN:   grad_reg = v[0];
        default: ;
      endcase
    endfunction

    function u64 mag(longint v);
      return v < 0 ? u64'(-v) : u64'(v);
    endfunction

    function u64 gauss_phi(int b, int nd);
      longint acc;
      u64     ad, sq, ar, t, a, k, fr;
      acc = 0;
      for (int i = 0; i < nd; i++) begin
        ad = mag(query_pt[i] - centre_mem[b*MAX_DIMS+i]);
        sq = (ad * ad) >> FRAC_BITS;
        ar = mag(width_mem[b*MAX_DIMS+i]);
        if (ar != 0 && sq > 64'hffff_ffff_ffff_ffff / ar) t = 64'd1 << 40;
        else begin
          t = (ar * sq) >> FRAC_BITS;
          if (t > (64'd1 << 40)) t = 64'd1 << 40;
        end
        acc += width_mem[b*MAX_DIMS+i] < 0 ? -longint'(t) : longint'(t);
      end
      if (acc <= 0) return exp_lut[0];
      if (acc >= (64'sd16 << FRAC_BITS)) return 0;
      a = u64'(acc);
      k = a >> (FRAC_BITS - 4);
      fr = a & ((64'd1 << (FRAC_BITS - 4)) - 1);
      return exp_lut[k] - (((exp_lut[k] - exp_lut[k+1]) * fr) >> (FRAC_BITS - 4));
    endfunction

    function void push_word(bit kind, int axis, longint v, bit last);
      rbf_word_t w;
      w.kind = kind;
      w.axis = axis[2:0];
      w.last = last;
      w.sat = 1;
      if (v > 64'sd2147483647) w.val = 32'h7fff_ffff;
      else if (v < -64'sd2147483648) w.val = 32'h8000_0000;
      else begin
        w.val = v[31:0];
        w.sat = 0;
      end
      pending.insert(pending.size(), w);
    endfunction

    // accepted input word: update stores, queue results of a query
    function void note_word(logic [1:0] op, int b, int d, bit [31:0] raw);
      longint                v;
      int                    nb, nd;
      longint                val_sum;
      longint                grad_sum[MAX_DIMS];
      longint                u, dv, w;
      u64                    au, aw, m;
      logic signed [127:0]   prod;
      v = longint'($signed(raw));
      case (op)
        OP_CENTER: centre_mem[b*MAX_DIMS+d] = v;
        OP_WIDTH:  width_mem[b*MAX_DIMS+d] = v;
        OP_WEIGHT: weight_mem[b] = v;
        default: ;
      endcase
      if (op != OP_COORD) return;
      query_pt[d] = v;
      nb = bases_reg == 0 ? 1 : (bases_reg > MAX_BASES ? MAX_BASES : bases_reg);
      nd = dims_reg == 0 ? 1 : (dims_reg > MAX_DIMS ? MAX_DIMS : dims_reg);
      if (d != nd - 1) return;
      val_sum = 0;
      foreach (grad_sum[i]) grad_sum[i] = 0;
      for (int j = 0; j < nb; j++) begin
        u = (weight_mem[j] * longint'(gauss_phi(j, nd))) >>> 30;
        au = mag(u);
        val_sum += u;
        if (!grad_reg) continue;
        for (int i = 0; i < nd; i++) begin
          dv = query_pt[i] - centre_mem[j*MAX_DIMS+i];
          prod = 128'(width_mem[j*MAX_DIMS+i]) * 128'(dv);
          prod = prod >>> FRAC_BITS;
          w = prod[63:0];
          aw = mag(w);
          if (au != 0 && aw > (64'd1 << 62) / au) m = 64'd1 << 54;
          else begin
            m = ((au * aw) << 1) >> FRAC_BITS;
            if (m > (64'd1 << 54)) m = 64'd1 << 54;
          end
          grad_sum[i] += ((u < 0) == (w < 0)) ? -longint'(m) : longint'(m);
        end
      end
      push_word(0, 0, val_sum, !grad_reg);
      if (grad_reg)
        for (int i = 0; i < nd; i++) push_word(1, i, grad_sum[i], i == nd - 1);
    endfunction

    function void check_word(bit kind, bit [2:0] axis, bit [31:0] val, bit sat, bit last);
      rbf_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word kind %0d axis %0d value %h", $time, kind, axis, val);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.kind !== kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (e.axis !== axis) begin
        $display("%0t: axis expected %0d actual %0d", $time, e.axis, axis);
        errors++;
      end
      if (e.val !== val) begin
        $display("%0t: result_value expected %h actual %h", $time, e.val, val);
        errors++;
      end
      if (e.sat !== sat) begin
        $display("%0t: saturated expected %0d actual %0d", $time, e.sat, sat);
        errors++;
      end
      if (e.last !== last) begin
        $display("%0t: last expected %0d actual %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [6:0]  cfg_wdata;

  rbf_scoreboard sb = new();
  int send_pct;
  int recv_pct;
  int rand_words;

  gaussian_rbf_network_eval dut (.*);

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_pct);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tuser[0], out_tdata[2:0], out_tdata[34:3], out_tuser[1], out_tlast);

  task automatic send_word(logic [1:0] op, int b, int d, bit [31:0] v);
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {7'd0, v, d[2:0], b[5:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(op, b, d, v);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(int nb, int nd, bit ge);
    drain();
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= CFG_NUM_BASES;
    cfg_wdata <= 7'(nb);
    @(posedge clk);
    sb.set_reg(CFG_NUM_BASES, nb);
    cfg_addr <= CFG_NUM_DIMS;
    cfg_wdata <= 7'(nd);
    @(posedge clk);
    sb.set_reg(CFG_NUM_DIMS, nd);
    cfg_addr <= CFG_GRAD_EN;
    cfg_wdata <= 7'(ge);
    @(posedge clk);
    sb.set_reg(CFG_GRAD_EN, ge);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // coordinates and centres mostly within a few units so phi is not zero
  function automatic bit [31:0] pick_pos();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic bit [31:0] pick_width();
    case ($urandom_range(9))
      0: return $urandom();
      1: return -$urandom_range(32'h0001_0000);
      default: return $urandom_range(32'h0000_8000);
    endcase
  endfunction

  function automatic bit [31:0] pick_weight();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      1, 2: return $urandom();
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic int eff_dims();
    int nd;
    nd = sb.dims_reg;
    return nd == 0 ? 1 : (nd > MAX_DIMS ? MAX_DIMS : nd);
  endfunction

  task automatic random_words(int n);
    int goal;
    int nd;
    goal = rand_words + n;
    while (rand_words < goal) begin
      send_pct = rand_words < 64 ? 16 : (rand_words < 128 ? 56 : 0);
      recv_pct = rand_words < 64 ? 56 : (rand_words < 128 ? 16 : 0);
      nd = eff_dims();
      if ($urandom_range(9) < 7) begin
        for (int i = 0; i < nd; i++) send_word(OP_COORD, 0, i, pick_pos());
        rand_words += nd;
      end else begin
        case ($urandom_range(3))
          0: send_word(OP_CENTER, $urandom_range(63), $urandom_range(7), pick_pos());
          1: send_word(OP_WIDTH, $urandom_range(63), $urandom_range(7), pick_width());
          2: send_word(OP_WEIGHT, $urandom_range(63), $urandom_range(7), pick_weight());
          default: send_word(OP_COORD, 0, $urandom_range(7), pick_pos());
        endcase
        rand_words++;
      end
    end
  endtask

  initial begin
    in_tvalid <= 0;
    in_tdata <= 0;
    in_tuser <= OP_CENTER;
    cfg_we <= 0;
    cfg_addr <= CFG_NUM_BASES;
    cfg_wdata <= 0;
    out_tready <= 0;
    send_pct = 0;
    recv_pct = 0;
    rand_words = 0;
    rst_n <= 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: one basis, one axis, reset configuration
    send_word(OP_CENTER, 0, 0, 32'h0000_0000);
    send_word(OP_WIDTH, 0, 0, 32'h0001_0000);
    send_word(OP_WEIGHT, 0, 0, 32'h0001_0000);
    send_word(OP_COORD, 0, 0, 32'h0000_0000);
    send_word(OP_COORD, 0, 0, 32'h0000_8000);
    send_word(OP_COORD, 0, 0, 32'h7fff_ffff);
    send_word(OP_COORD, 0, 0, 32'h8000_0000);
    // negative width: exponent sum below zero
    send_word(OP_WIDTH, 0, 0, 32'hffff_0000);
    send_word(OP_COORD, 0, 0, 32'h0003_0000);
    send_word(OP_WEIGHT, 0, 0, 32'h7fff_ffff);
    send_word(OP_COORD, 0, 0, 32'h7fff_ffff);
    send_word(OP_WEIGHT, 0, 0, 32'h8000_0000);
    send_word(OP_COORD, 0, 0, 32'h8000_0000);
    send_word(OP_WIDTH, 0, 0, 32'h7fff_ffff);
    send_word(OP_CENTER, 0, 0, 32'h8000_0000);
    send_word(OP_COORD, 0, 0, 32'h7fff_ffff);
    send_word(OP_WIDTH, 0, 0, 32'h8000_0000);
    send_word(OP_COORD, 0, 0, 32'h0000_0001);
    write_regs(1, 1, 0);
    send_word(OP_COORD, 0, 0, 32'hffff_ffff);

    // every basis on axis 0, the first four bases on every axis
    write_regs(4, 8, 1);
    for (int b = 0; b < MAX_BASES; b++) begin
      send_word(OP_CENTER, b, 0, pick_pos());
      send_word(OP_WIDTH, b, 0, pick_width());
      send_word(OP_WEIGHT, b, 0, pick_weight());
    end
    for (int b = 0; b < 4; b++) begin
      for (int d = 1; d < MAX_DIMS; d++) begin
        send_word(OP_CENTER, b, d, pick_pos());
        send_word(OP_WIDTH, b, d, pick_width());
      end
    end
    for (int d = 0; d < MAX_DIMS - 1; d++) send_word(OP_COORD, 0, d, pick_pos());

    random_words(30);
    write_regs(3, 2, 1);
    random_words(30);
    drain();
    write_regs(127, 1, 0);
    random_words(30);
    write_regs(0, 0, 1);
    random_words(30);
    write_regs(4, 15, 1);
    random_words(25);
    write_regs(64, 1, 1);
    random_words(25);
    write_regs(1, 8, 0);
    random_words(20);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
